@@ rtl/core/pfe_pkg.sv @@
// Package for the palette fade engine: command and target codes, the issue
// record passed from the sequencer to the output stage, and dimming functions.
// No dependencies.
`timescale 1ns / 1ps

package pfe_pkg;

  // Default number of color entries per palette bank
  localparam int unsigned COLOR_ENTRIES_DEF = 32;

  // Mono palette byte after reset or clear, and the all-black mono byte
  localparam logic [7:0] MONO_RESET = 8'hE4;
  localparam logic [7:0] MONO_BLACK = 8'hFF;

  // Step code that marks the trailing ticks after the final fade step
  localparam logic [2:0] TAIL_PHASE = 3'd7;

  // Fade step values at the start and end of each sequence
  localparam logic [2:0] STEP_ZERO      = 3'd0;
  localparam logic [2:0] STEP_ONE       = 3'd1;
  localparam logic [2:0] STEP_COLOR_OUT = 3'd3;
  localparam logic [2:0] STEP_COLOR_MAX = 3'd4;
  localparam logic [2:0] STEP_MONO_MAX  = 3'd3;

  typedef enum logic [2:0] {
    FUNC_CLEAR    = 3'd0,
    FUNC_BG_WR    = 3'd1,
    FUNC_SP_WR    = 3'd2,
    FUNC_MONO     = 3'd3,
    FUNC_BLACK    = 3'd4,
    FUNC_FADE_OUT = 3'd5,
    FUNC_FADE_IN  = 3'd6,
    FUNC_VBLANK   = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    TGT_BG_COLOR  = 3'd0,
    TGT_SP_COLOR  = 3'd1,
    TGT_BG_MONO   = 3'd2,
    TGT_OBJ0_MONO = 3'd3,
    TGT_OBJ1_MONO = 3'd4
  } target_e;

  // One result request from the sequencer
  typedef struct packed {
    logic        valid;
    logic        use_mem;  // value comes from the shadow memory, dimmed
    target_e     target;
    logic [4:0]  index;
    logic [14:0] imm;      // value when use_mem is low
    logic [2:0]  step;
    logic        last;
    logic        done;
  } issue_t;

  // Scale each RGB555 channel by s/4; step 0 is black, 4 and up pass through
  function automatic logic [14:0] dim_rgb(logic [14:0] c, logic [2:0] s);
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [14:0] res;
    r = 8'(c[4:0]) * 8'(s[1:0]);
    g = 8'(c[9:5]) * 8'(s[1:0]);
    b = 8'(c[14:10]) * 8'(s[1:0]);
    if (s == STEP_ZERO) begin
      res = '0;
    end else if (s >= STEP_COLOR_MAX) begin
      res = c;
    end else begin
      res = {b[6:2], g[6:2], r[6:2]};
    end
    return res;
  endfunction

  // Add s to each 2-bit shade, saturating at 3
  function automatic logic [7:0] dim_mono(logic [7:0] p, logic [2:0] s);
    logic [7:0] res;
    logic [2:0] v;
    res = '0;
    if (s == STEP_ZERO) begin
      res = p;
    end else if (s >= STEP_MONO_MAX) begin
      res = MONO_BLACK;
    end else begin
      for (int k = 0; k < 4; k++) begin
        v = 3'(p[2*k +: 2]) + s;
        if (v > 3'd3) begin
          v = 3'd3;
        end
        res[2*k +: 2] = v[1:0];
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/core/pfe_intf.sv @@
// Valid/ready channel interfaces for the palette fade engine: command input,
// result output and the color mode register write. Depends on nothing.
`timescale 1ns / 1ps

interface pfe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [4:0]  entry_index;
  logic [14:0] color_value;
  logic [7:0]  bg_shades;
  logic [7:0]  obj0_shades;
  logic [7:0]  obj1_shades;
  logic [7:0]  frame_delay;

  modport source (
    output valid, func, entry_index, color_value, bg_shades, obj0_shades,
           obj1_shades, frame_delay,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, color_value, bg_shades, obj0_shades,
           obj1_shades, frame_delay,
    output ready
  );
endinterface

interface pfe_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [4:0]  out_index;
  logic [14:0] out_value;
  logic        last;
  logic        fade_done;

  modport source (
    output valid, target, out_index, out_value, last, fade_done,
    input  ready
  );
  modport sink (
    input  valid, target, out_index, out_value, last, fade_done,
    output ready
  );
endinterface

interface pfe_cfg_if;
  logic valid;
  logic ready;
  logic color_mode;

  modport source (
    output valid, color_mode,
    input  ready
  );
  modport sink (
    input  valid, color_mode,
    output ready
  );
endinterface

@@ rtl/core/pfe_shadow_mem.sv @@
// Shadow color memory: background entries in the lower half, sprite entries
// in the upper half. Per-entry valid bits make unwritten entries read as zero.
`timescale 1ns / 1ps

module pfe_shadow_mem #(
  parameter int unsigned AW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [14:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [14:0]   rd_data_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [14:0]      mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [DEPTH-1:0] vld_d;
  logic [14:0]      rd_data_q;

  // Valid bits: cleared by reset and by the clear command
  always_comb begin
    vld_d = vld_q;
    if (clr_i) begin
      vld_d = '0;
    end else if (wr_en_i) begin
      vld_d[wr_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Array write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read; holds while no read is requested
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= vld_q[rd_addr_i] ? mem_q[rd_addr_i] : 15'd0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/pfe_ctrl.sv @@
// Command decode, fade state and result sequencer of the palette fade engine.
// Uses pfe_pkg and the channel interfaces; drives the shadow memory ports.
`timescale 1ns / 1ps

module pfe_ctrl #(
  parameter int unsigned COLOR_ENTRIES = pfe_pkg::COLOR_ENTRIES_DEF,
  parameter int unsigned IW = $clog2(COLOR_ENTRIES),
  parameter int unsigned AW = IW + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pfe_in_if.sink          in_i,
  pfe_cfg_if.sink         cfg_i,
  input  logic            s1_free_i,
  output pfe_pkg::issue_t issue_o,
  output logic            mem_clr_o,
  output logic            mem_wr_en_o,
  output logic [AW-1:0]   mem_wr_addr_o,
  output logic [14:0]     mem_wr_data_o,
  output logic            mem_rd_en_o,
  output logic [AW-1:0]   mem_rd_addr_o
);

  localparam int unsigned CW = $clog2(COLOR_ENTRIES + 1);
  localparam logic [6:0]  CE7 = 7'(COLOR_ENTRIES);

  // Sequencer states
  localparam logic [1:0] SEQ_IDLE  = 2'd0;
  localparam logic [1:0] SEQ_COLOR = 2'd1;
  localparam logic [1:0] SEQ_MONO  = 2'd2;
  localparam logic [1:0] SEQ_ONE   = 2'd3;

  // Fade and shadow state
  logic       color_mode_q, color_mode_d;
  logic [3:0] bg_act_q, bg_act_d;
  logic [3:0] sp_act_q, sp_act_d;
  logic [7:0] mono_q [3];
  logic [7:0] mono_d [3];
  logic       fading_q, fading_d;
  logic       inward_q, inward_d;
  logic [2:0] step_q, step_d;
  logic [7:0] wait_q, wait_d;
  logic [7:0] delay_q, delay_d;

  // Sequencer state
  logic [1:0]    seq_q, seq_d;
  logic          side_q, side_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] bg_n_q, bg_n_d;
  logic [CW-1:0] sp_n_q, sp_n_d;
  logic [2:0]    sstep_q, sstep_d;
  logic          sdone_q, sdone_d;
  logic [14:0]   one_val_q, one_val_d;
  logic [4:0]    one_idx_q, one_idx_d;
  logic          one_sp_q, one_sp_d;

  // Helpers
  pfe_pkg::func_e func;
  logic           in_fire;
  logic           fire;
  logic [CW-1:0]  idx_inc;
  logic           more_bg;
  logic           more_sp;
  logic           fin;
  logic [7:0]     wait_dec;
  logic [7:0]     delay_m1;
  logic [6:0]     bg_cnt7;
  logic [6:0]     sp_cnt7;
  logic [CW-1:0]  bg_cnt;
  logic [CW-1:0]  sp_cnt;
  logic           idx_ok;
  logic [3:0]     pal;
  logic [7:0]     mono_sel;

  assign func        = pfe_pkg::func_e'(in_i.func);
  assign in_i.ready  = (seq_q == SEQ_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign idx_inc  = CW'(idx_q) + CW'(1);
  assign more_bg  = idx_inc < bg_n_q;
  assign more_sp  = idx_inc < sp_n_q;
  assign wait_dec = wait_q - 8'd1;
  assign delay_m1 = delay_q - 8'd1;

  // Active entry counts, capped at the bank size
  always_comb begin
    bg_cnt7 = {1'b0, bg_act_q, 2'b00};
    sp_cnt7 = {1'b0, sp_act_q, 2'b00};
    if (bg_cnt7 > CE7) begin
      bg_cnt7 = CE7;
    end
    if (sp_cnt7 > CE7) begin
      sp_cnt7 = CE7;
    end
  end
  assign bg_cnt = CW'(bg_cnt7);
  assign sp_cnt = CW'(sp_cnt7);

  // Final-step test for the current mode and direction
  always_comb begin
    if (color_mode_q) begin
      fin = inward_q ? (step_q >= pfe_pkg::STEP_COLOR_MAX) : (step_q == pfe_pkg::STEP_ZERO);
    end else begin
      fin = inward_q ? (step_q == pfe_pkg::STEP_ZERO) : (step_q >= pfe_pkg::STEP_MONO_MAX);
    end
  end

  assign idx_ok = 32'(in_i.entry_index) < COLOR_ENTRIES;
  assign pal    = 4'(in_i.entry_index[4:2]) + 4'd1;

  // Mono byte for the current sequencer slot
  always_comb begin
    unique case (idx_q[1:0])
      2'd0:    mono_sel = mono_q[0];
      2'd1:    mono_sel = mono_q[1];
      default: mono_sel = mono_q[2];
    endcase
  end

  // Result request for the current sequencer slot
  always_comb begin
    issue_o = '0;
    issue_o.step = sstep_q;
    issue_o.done = sdone_q;
    unique case (seq_q)
      SEQ_COLOR: begin
        issue_o.valid   = 1'b1;
        issue_o.use_mem = 1'b1;
        issue_o.target  = side_q ? pfe_pkg::TGT_SP_COLOR : pfe_pkg::TGT_BG_COLOR;
        issue_o.index   = 5'(idx_q);
        issue_o.last    = side_q ? !more_sp : (!more_bg && (sp_n_q == '0));
      end
      SEQ_MONO: begin
        issue_o.valid = 1'b1;
        issue_o.imm   = 15'(pfe_pkg::dim_mono(mono_sel, sstep_q));
        issue_o.last  = (idx_q[1:0] == 2'd2);
        unique case (idx_q[1:0])
          2'd0:    issue_o.target = pfe_pkg::TGT_BG_MONO;
          2'd1:    issue_o.target = pfe_pkg::TGT_OBJ0_MONO;
          default: issue_o.target = pfe_pkg::TGT_OBJ1_MONO;
        endcase
      end
      SEQ_ONE: begin
        issue_o.valid  = 1'b1;
        issue_o.target = one_sp_q ? pfe_pkg::TGT_SP_COLOR : pfe_pkg::TGT_BG_COLOR;
        issue_o.index  = one_idx_q;
        issue_o.imm    = one_val_q;
        issue_o.last   = 1'b1;
      end
      default: ;
    endcase
  end

  assign fire          = issue_o.valid && s1_free_i;
  assign mem_rd_en_o   = fire && (seq_q == SEQ_COLOR);
  assign mem_rd_addr_o = {side_q, idx_q};

  // Next state: sequencer advance and command decode
  always_comb begin
    color_mode_d = color_mode_q;
    bg_act_d     = bg_act_q;
    sp_act_d     = sp_act_q;
    mono_d       = mono_q;
    fading_d     = fading_q;
    inward_d     = inward_q;
    step_d       = step_q;
    wait_d       = wait_q;
    delay_d      = delay_q;
    seq_d        = seq_q;
    side_d       = side_q;
    idx_d        = idx_q;
    bg_n_d       = bg_n_q;
    sp_n_d       = sp_n_q;
    sstep_d      = sstep_q;
    sdone_d      = sdone_q;
    one_val_d    = one_val_q;
    one_idx_d    = one_idx_q;
    one_sp_d     = one_sp_q;
    mem_clr_o     = 1'b0;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = {(func == pfe_pkg::FUNC_SP_WR), IW'(in_i.entry_index)};
    mem_wr_data_o = in_i.color_value;

    if (cfg_i.valid) begin
      color_mode_d = cfg_i.color_mode;
    end

    // Walk to the next result
    if (fire) begin
      unique case (seq_q)
        SEQ_COLOR: begin
          if (!side_q && more_bg) begin
            idx_d = idx_q + IW'(1);
          end else if (!side_q && (sp_n_q != '0)) begin
            side_d = 1'b1;
            idx_d  = '0;
          end else if (side_q && more_sp) begin
            idx_d = idx_q + IW'(1);
          end else begin
            seq_d = SEQ_IDLE;
          end
        end
        SEQ_MONO: begin
          if (idx_q[1:0] == 2'd2) begin
            seq_d = SEQ_IDLE;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
        default: seq_d = SEQ_IDLE;
      endcase
    end

    // Accepted request
    if (in_fire) begin
      side_d  = 1'b0;
      idx_d   = '0;
      sdone_d = 1'b0;
      if (func == pfe_pkg::FUNC_VBLANK) begin
        if (fading_q) begin
          if (wait_q != 8'd0) begin
            wait_d = wait_dec;
            if ((wait_dec == 8'd0) && (step_q == pfe_pkg::TAIL_PHASE)) begin
              fading_d = 1'b0;
              step_d   = pfe_pkg::STEP_ZERO;
            end
          end else if (step_q == pfe_pkg::TAIL_PHASE) begin
            fading_d = 1'b0;
            step_d   = pfe_pkg::STEP_ZERO;
          end else begin
            // Apply one fade step
            sstep_d = step_q;
            sdone_d = fin;
            if (color_mode_q) begin
              bg_n_d = bg_cnt;
              sp_n_d = sp_cnt;
              if (bg_cnt != '0) begin
                seq_d = SEQ_COLOR;
              end else if (sp_cnt != '0) begin
                seq_d  = SEQ_COLOR;
                side_d = 1'b1;
              end
            end else begin
              seq_d = SEQ_MONO;
            end
            wait_d = delay_m1;
            if (fin) begin
              if (delay_m1 == 8'd0) begin
                fading_d = 1'b0;
                step_d   = pfe_pkg::STEP_ZERO;
              end else begin
                step_d = pfe_pkg::TAIL_PHASE;
              end
            end else if (color_mode_q ? inward_q : !inward_q) begin
              step_d = step_q + 3'd1;
            end else begin
              step_d = step_q - 3'd1;
            end
          end
        end
      end else if (!fading_q) begin
        unique case (func)
          pfe_pkg::FUNC_CLEAR: begin
            mem_clr_o = 1'b1;
            bg_act_d  = '0;
            sp_act_d  = '0;
            for (int k = 0; k < 3; k++) begin
              mono_d[k] = pfe_pkg::MONO_RESET;
            end
          end
          pfe_pkg::FUNC_BG_WR, pfe_pkg::FUNC_SP_WR: begin
            if (color_mode_q) begin
              one_val_d = in_i.color_value;
              one_idx_d = in_i.entry_index;
              one_sp_d  = (func == pfe_pkg::FUNC_SP_WR);
              seq_d     = SEQ_ONE;
              if (idx_ok) begin
                mem_wr_en_o = 1'b1;
                if (func == pfe_pkg::FUNC_SP_WR) begin
                  if (pal > sp_act_q) begin
                    sp_act_d = pal;
                  end
                end else if (pal > bg_act_q) begin
                  bg_act_d = pal;
                end
              end
            end
          end
          pfe_pkg::FUNC_MONO: begin
            mono_d[0] = in_i.bg_shades;
            mono_d[1] = in_i.obj0_shades;
            mono_d[2] = in_i.obj1_shades;
            sstep_d   = pfe_pkg::STEP_ZERO;
            seq_d     = SEQ_MONO;
          end
          pfe_pkg::FUNC_BLACK: begin
            // Color black reads every entry and dims it by step zero
            if (color_mode_q) begin
              bg_n_d  = CW'(COLOR_ENTRIES);
              sp_n_d  = CW'(COLOR_ENTRIES);
              sstep_d = pfe_pkg::STEP_ZERO;
              seq_d   = SEQ_COLOR;
            end else begin
              sstep_d = pfe_pkg::STEP_MONO_MAX;
              seq_d   = SEQ_MONO;
            end
          end
          pfe_pkg::FUNC_FADE_OUT, pfe_pkg::FUNC_FADE_IN: begin
            inward_d = (func == pfe_pkg::FUNC_FADE_IN);
            if (color_mode_q) begin
              step_d = inward_d ? pfe_pkg::STEP_ONE : pfe_pkg::STEP_COLOR_OUT;
            end else begin
              step_d = inward_d ? pfe_pkg::STEP_MONO_MAX : pfe_pkg::STEP_ONE;
            end
            delay_d  = (in_i.frame_delay == 8'd0) ? 8'd1 : in_i.frame_delay;
            wait_d   = 8'd0;
            fading_d = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Control and fade state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b1;
      bg_act_q     <= '0;
      sp_act_q     <= '0;
      for (int k = 0; k < 3; k++) begin
        mono_q[k] <= pfe_pkg::MONO_RESET;
      end
      fading_q <= 1'b0;
      inward_q <= 1'b0;
      step_q   <= pfe_pkg::STEP_ZERO;
      wait_q   <= 8'd0;
      delay_q  <= 8'd1;
      seq_q    <= SEQ_IDLE;
    end else begin
      color_mode_q <= color_mode_d;
      bg_act_q     <= bg_act_d;
      sp_act_q     <= sp_act_d;
      mono_q       <= mono_d;
      fading_q     <= fading_d;
      inward_q     <= inward_d;
      step_q       <= step_d;
      wait_q       <= wait_d;
      delay_q      <= delay_d;
      seq_q        <= seq_d;
    end
  end

  // Sequencer payload registers
  always_ff @(posedge clk_i) begin
    side_q    <= side_d;
    idx_q     <= idx_d;
    bg_n_q    <= bg_n_d;
    sp_n_q    <= sp_n_d;
    sstep_q   <= sstep_d;
    sdone_q   <= sdone_d;
    one_val_q <= one_val_d;
    one_idx_q <= one_idx_d;
    one_sp_q  <= one_sp_d;
  end

endmodule

@@ rtl/core/pfe_out_stage.sv @@
// Output pipeline: a stage that waits for shadow read data, color dimming,
// and the output register. Uses pfe_pkg and the result channel interface.
`timescale 1ns / 1ps

module pfe_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pfe_pkg::issue_t issue_i,
  output logic            s1_free_o,
  input  logic [14:0]     rd_data_i,
  pfe_out_if.source       out_o
);

  logic            s1_valid_q;
  pfe_pkg::issue_t s1_q;
  logic            out_valid_q;
  logic [2:0]      target_q;
  logic [4:0]      index_q;
  logic [14:0]     value_q;
  logic            last_q;
  logic            done_q;
  logic            out_free;
  logic [14:0]     s1_value;

  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_free_o = !s1_valid_q || out_free;

  // Dim the shadow color or pass the immediate value
  assign s1_value = s1_q.use_mem ? pfe_pkg::dim_rgb(rd_data_i, s1_q.step) : s1_q.imm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free_o) begin
        s1_valid_q <= issue_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s1_free_o && issue_i.valid) begin
      s1_q <= issue_i;
    end
    if (out_free && s1_valid_q) begin
      target_q <= s1_q.target;
      index_q  <= s1_q.index;
      value_q  <= s1_value;
      last_q   <= s1_q.last;
      done_q   <= s1_q.done;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.target    = target_q;
  assign out_o.out_index = index_q;
  assign out_o.out_value = value_q;
  assign out_o.last      = last_q;
  assign out_o.fade_done = done_q;

endmodule

@@ rtl/core/palette_fade_engine_core.sv @@
// Palette fade engine top level: sequencer, shadow color memory, output stage.
// Depends on pfe_pkg, pfe_intf, pfe_ctrl, pfe_shadow_mem and pfe_out_stage.
`timescale 1ns / 1ps

// Usage:
//   in_i carries one command request (func and its operands); out_o carries
//   palette write results (target, index, value, last, fade_done); cfg_i
//   writes color_mode and is always ready.
//   A request is taken only while the sequencer is idle. Requests with no
//   result (clear, fade arm, silent ticks, any other command while a fade
//   runs) leave the sequencer idle. A request with n results occupies the
//   sequencer until all of them have left it: one result each cycle while
//   out_o does not stall, one shadow memory read per color entry, so a full
//   color step of 64 entries makes 64 reads. The first result passes the
//   one-entry stage and the output register before it shows on out_o.
//   A stalled out_o holds its result; the one-entry stage behind it and the
//   registered memory read data hold too, and the sequencer pauses without losing its place.
//   Reset clears the fade state, the active palette counts and every shadow
//   entry valid bit at once (unwritten entries read as black), loads the
//   mono bytes with 0xE4 and sets color mode; no clearing pass is needed.
module palette_fade_engine_core #(
  parameter int unsigned COLOR_ENTRIES = pfe_pkg::COLOR_ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfe_in_if.sink    in_i,
  pfe_cfg_if.sink   cfg_i,
  pfe_out_if.source out_o
);

  localparam int unsigned IW = $clog2(COLOR_ENTRIES);
  localparam int unsigned AW = IW + 1;

  pfe_pkg::issue_t issue;
  logic            s1_free;
  logic            mem_clr;
  logic            mem_wr_en;
  logic [AW-1:0]   mem_wr_addr;
  logic [14:0]     mem_wr_data;
  logic            mem_rd_en;
  logic [AW-1:0]   mem_rd_addr;
  logic [14:0]     mem_rd_data;

  // Command decode and result sequencer
  pfe_ctrl #(
    .COLOR_ENTRIES (COLOR_ENTRIES),
    .IW            (IW),
    .AW            (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .cfg_i         (cfg_i),
    .s1_free_i     (s1_free),
    .issue_o       (issue),
    .mem_clr_o     (mem_clr),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr)
  );

  // Background and sprite shadow colors
  pfe_shadow_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (mem_clr),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // Dimming and output register
  pfe_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .s1_free_o (s1_free),
    .rd_data_i (mem_rd_data),
    .out_o     (out_o)
  );

endmodule
